// ===== sv/graph_majority_update_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the graph majority update block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRAPH_MAJORITY_UPDATE_ASSERT_SVH
`define GRAPH_MAJORITY_UPDATE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define GMU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define GMU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GMU_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define GMU_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== sv/gmu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmu_pkg
// Types and constants of the graph majority update block.
// ----------------------------------------------------------------------------
package gmu_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int MAX_DEGREE   = 8;

   localparam int VTX_W  = $clog2(MAX_VERTICES);     // vertex index
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1); // vertex count
   localparam int SLOT_W = $clog2(MAX_DEGREE);       // neighbor slot
   localparam int DEG_W  = $clog2(MAX_DEGREE + 1);   // neighbor count
   localparam int CMD_W  = 3;
   localparam int VAL_W  = 8;
   localparam int COLOR_W = 8;
   localparam int DIM_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Commands
   localparam logic [CMD_W-1:0] CMD_WRITE_COLOR    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_DEGREE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE_NEIGHBOR = 3'd2;
   localparam logic [CMD_W-1:0] CMD_UPDATE         = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_COLOR     = 3'd4;

   // Status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_ONE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_TWO = 2'd3;

   // Register reset values
   localparam logic [DIM_W-1:0]   ROW_COUNT_RST = 5'd16;
   localparam logic [DIM_W-1:0]   COL_COUNT_RST = 5'd16;
   localparam logic [COLOR_W-1:0] COLOR_ONE_RST = 8'd46;  // '.'
   localparam logic [COLOR_W-1:0] COLOR_TWO_RST = 8'd88;  // 'X'

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [VTX_W-1:0]  vertex;
      logic [SLOT_W-1:0] slot;
      logic [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] read_color;
      logic               status;
   } rsp_type;

endpackage

// ===== sv/graph_majority_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_majority_update
// Vertex color store with adjacency lists and a synchronous majority round.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   req_*     in          req_valid/req_stall  gmu_pkg::req_type
//   rsp_*     out         rsp_valid/rsp_stall  gmu_pkg::rsp_type
//   csr_*     in          csr_we               csr_index, csr_wdata
//
// Load and error requests pass the done state, a color read also the
// read-wait state, on the way to the output register. An update round walks
// all 256 vertices in turn, streaming each neighbor list through adjacency
// read, color lookup and tally; vertices beyond the count or with no
// neighbors skip the stream. The color memory has a single read port.
// Reset is synchronous; the color, degree and adjacency memories hold no
// reset value and must be loaded before use. A stalled response holds in the
// output register while the next request is already taken and worked on.
//
`include "graph_majority_update_assert.svh"

module graph_majority_update (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  gmu_pkg::req_type                   req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output gmu_pkg::rsp_type                   rsp_data,
   // register write port
   input  logic                               csr_we,
   input  logic [gmu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gmu_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gmu_pkg::*;

   // State codes of the sequencer
   localparam logic [2:0] S_IDLE   = 3'd0;  // wait for a request
   localparam logic [2:0] S_RDWAIT = 3'd1;  // color read in flight
   localparam logic [2:0] S_DONE   = 3'd2;  // result waits for output register
   localparam logic [2:0] S_VTX    = 3'd3;  // fetch degree and own color
   localparam logic [2:0] S_OWN    = 3'd4;  // latch degree and own color
   localparam logic [2:0] S_NBR    = 3'd5;  // stream the neighbor list
   localparam logic [2:0] S_WRITE  = 3'd6;  // store new color in spare bank

   localparam int COL_AW = VTX_W + 1;
   localparam int ADJ_AW = VTX_W + SLOT_W;

   // ---------------------------------------------------------------------
   // Storage: both color banks share one memory, bank bit on top.
   // ---------------------------------------------------------------------
   logic [COLOR_W-1:0] color_mem [2*MAX_VERTICES];
   logic [DEG_W-1:0]   deg_mem   [MAX_VERTICES];
   logic [VTX_W-1:0]   adj_mem   [MAX_VERTICES*MAX_DEGREE];

   logic               col_we;
   logic [COL_AW-1:0]  col_waddr;
   logic [COLOR_W-1:0] col_wdata;
   logic [COL_AW-1:0]  col_raddr;
   logic [COLOR_W-1:0] col_rd_ff;

   logic               deg_we;
   logic [VTX_W-1:0]   deg_waddr;
   logic [DEG_W-1:0]   deg_wdata;
   logic [VTX_W-1:0]   deg_raddr;
   logic [DEG_W-1:0]   deg_rd_ff;

   logic               adj_we;
   logic [ADJ_AW-1:0]  adj_waddr;
   logic [VTX_W-1:0]   adj_wdata;
   logic [ADJ_AW-1:0]  adj_raddr;
   logic [VTX_W-1:0]   adj_rd_ff;

   always_ff @(posedge clock) begin
      if (col_we) begin
         color_mem[col_waddr] <= col_wdata;
      end
      col_rd_ff <= color_mem[col_raddr];
   end

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_waddr] <= deg_wdata;
      end
      deg_rd_ff <= deg_mem[deg_raddr];
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_waddr] <= adj_wdata;
      end
      adj_rd_ff <= adj_mem[adj_raddr];
   end

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0]   row_ff;
   logic [DIM_W-1:0]   col_ff;
   logic [COLOR_W-1:0] one_ff;
   logic [COLOR_W-1:0] two_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= ROW_COUNT_RST;
         col_ff <= COL_COUNT_RST;
         one_ff <= COLOR_ONE_RST;
         two_ff <= COLOR_TWO_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_ff <= csr_wdata[DIM_W-1:0];
            CSR_COL_COUNT: col_ff <= csr_wdata[DIM_W-1:0];
            CSR_COLOR_ONE: one_ff <= csr_wdata[COLOR_W-1:0];
            CSR_COLOR_TWO: two_ff <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Vertex count: rows times columns, saturated at the table size.
   logic [2*DIM_W-1:0] grid_size;
   logic [CNT_W-1:0]   vtx_count;

   assign grid_size = row_ff * col_ff;
   assign vtx_count = (grid_size > (2*DIM_W)'(MAX_VERTICES)) ?
                      CNT_W'(MAX_VERTICES) : grid_size[CNT_W-1:0];

   // ---------------------------------------------------------------------
   // Sequencer registers
   // ---------------------------------------------------------------------
   logic [2:0]         state_ff,  state_in;
   logic               bank_ff,   bank_in;    // bank holding current colors
   logic [VTX_W-1:0]   vtx_ff,    vtx_in;     // vertex under update
   logic [DEG_W-1:0]   issue_ff,  issue_in;   // neighbor reads issued
   logic [DEG_W-1:0]   deg_ff,    deg_in;     // clamped degree
   logic [COLOR_W-1:0] own_ff,    own_in;     // vertex's own color
   logic [DEG_W-1:0]   ones_ff,   ones_in;
   logic [DEG_W-1:0]   twos_ff,   twos_in;
   logic               p1_ff,     p1_in;      // neighbor index on adj read data
   logic               p2_ff,     p2_in;      // neighbor color on color read data
   rsp_type            res_ff,    res_in;     // pending result
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff,    rsp_in;

   logic               req_accept;
   logic               rsp_load;
   logic               req_vtx_ok;
   logic               req_deg_ok;
   logic               req_slot_ok;
   logic               req_nb_ok;
   logic               vtx_live;
   logic               nb_live;
   logic               last_vtx;
   logic [DEG_W-1:0]   deg_clamp;
   logic [COLOR_W-1:0] next_color;
   logic [DEG_W:0]     tally_sum;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   // Output register frees when empty or when its response is taken now.
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign req_vtx_ok  = ({1'b0, req_data.vertex} < vtx_count);
   assign req_deg_ok  = (req_data.value <= VAL_W'(MAX_DEGREE));
   assign req_slot_ok = ({1'b0, req_data.slot} < (SLOT_W+1)'(MAX_DEGREE));
   assign req_nb_ok   = ({1'b0, req_data.value} < vtx_count);

   assign vtx_live  = ({1'b0, vtx_ff} < vtx_count);
   // A neighbor entry left over from a larger grid is not counted.
   assign nb_live   = ({1'b0, adj_rd_ff} < vtx_count);
   assign last_vtx  = (vtx_ff == VTX_W'(MAX_VERTICES - 1));
   assign deg_clamp = (deg_rd_ff > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_rd_ff;
   assign tally_sum = {1'b0, ones_ff} + {1'b0, twos_ff};

   // Strict majority wins; a tie keeps the vertex's own color.
   always_comb begin
      if (ones_ff > twos_ff) begin
         next_color = one_ff;
      end else if (twos_ff > ones_ff) begin
         next_color = two_ff;
      end else begin
         next_color = own_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      bank_in   = bank_ff;
      vtx_in    = vtx_ff;
      issue_in  = issue_ff;
      deg_in    = deg_ff;
      own_in    = own_ff;
      ones_in   = ones_ff;
      twos_in   = twos_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      res_in    = res_ff;

      col_we    = 1'b0;
      col_waddr = {~bank_ff, vtx_ff};
      col_wdata = next_color;
      col_raddr = {bank_ff, vtx_ff};
      deg_we    = 1'b0;
      deg_waddr = req_data.vertex;
      deg_wdata = req_data.value[DEG_W-1:0];
      deg_raddr = vtx_ff;
      adj_we    = 1'b0;
      adj_waddr = {req_data.vertex, req_data.slot};
      adj_wdata = req_data.value;
      adj_raddr = {vtx_ff, issue_ff[SLOT_W-1:0]};

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_in.read_color = '0;
               res_in.status     = STATUS_OK;
               state_in          = S_DONE;
               unique case (req_data.command)
                  CMD_WRITE_COLOR: begin
                     if (req_vtx_ok) begin
                        col_we    = 1'b1;
                        col_waddr = {bank_ff, req_data.vertex};
                        col_wdata = req_data.value;
                     end else begin
                        res_in.status = STATUS_ERROR;
                     end
                  end
                  CMD_WRITE_DEGREE: begin
                     if (req_vtx_ok && req_deg_ok) begin
                        deg_we = 1'b1;
                     end else begin
                        res_in.status = STATUS_ERROR;
                     end
                  end
                  CMD_WRITE_NEIGHBOR: begin
                     if (req_vtx_ok && req_slot_ok && req_nb_ok) begin
                        adj_we = 1'b1;
                     end else begin
                        res_in.status = STATUS_ERROR;
                     end
                  end
                  CMD_UPDATE: begin
                     vtx_in   = '0;
                     state_in = S_VTX;
                  end
                  CMD_READ_COLOR: begin
                     if (req_vtx_ok) begin
                        col_raddr = {bank_ff, req_data.vertex};
                        state_in  = S_RDWAIT;
                     end else begin
                        res_in.status = STATUS_ERROR;
                     end
                  end
                  default: begin
                     res_in.status = STATUS_ERROR;
                  end
               endcase
            end
         end

         S_RDWAIT: begin
            res_in.read_color = col_rd_ff;
            state_in          = S_DONE;
         end

         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         S_VTX: begin
            // Read degree and own color; clear the tallies.
            ones_in  = '0;
            twos_in  = '0;
            issue_in = '0;
            p1_in    = 1'b0;
            p2_in    = 1'b0;
            state_in = S_OWN;
         end

         S_OWN: begin
            own_in = col_rd_ff;
            deg_in = deg_clamp;
            // Vertices beyond the count copy their color unchanged.
            if (!vtx_live || (deg_clamp == '0)) begin
               state_in = S_WRITE;
            end else begin
               state_in = S_NBR;
            end
         end

         S_NBR: begin
            // Stage 1: issue the next adjacency read.
            if (issue_ff != deg_ff) begin
               issue_in = issue_ff + 1'b1;
               p1_in    = 1'b1;
            end else begin
               p1_in    = 1'b0;
            end
            // Stage 2: look up the neighbor's current color.
            col_raddr = {bank_ff, adj_rd_ff};
            p2_in     = p1_ff && nb_live;
            // Stage 3: tally the neighbor color.
            if (p2_ff) begin
               if (col_rd_ff == one_ff) begin
                  ones_in = ones_ff + 1'b1;
               end else if (col_rd_ff == two_ff) begin
                  twos_in = twos_ff + 1'b1;
               end
            end
            if ((issue_ff == deg_ff) && !p1_ff && !p2_ff) begin
               state_in = S_WRITE;
            end
         end

         S_WRITE: begin
            col_we = 1'b1;
            if (last_vtx) begin
               // Swap banks so every vertex changes at once.
               bank_in           = ~bank_ff;
               res_in.read_color = '0;
               res_in.status     = STATUS_OK;
               state_in          = S_DONE;
            end else begin
               vtx_in   = vtx_ff + 1'b1;
               state_in = S_VTX;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load a finished result, hold while stalled.
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_load ? res_ff : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bank_ff      <= 1'b0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vtx_ff   <= vtx_in;
      issue_ff <= issue_in;
      deg_ff   <= deg_in;
      own_ff   <= own_in;
      ones_ff  <= ones_in;
      twos_ff  <= twos_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `GMU_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != S_IDLE, "request taken but sequencer stayed idle")
   `GMU_ASSERT_NXT(a_done_loads_output, clock, reset, rsp_load, rsp_valid_ff, "finished result not loaded into output register")
   `GMU_ASSERT_IMP(a_tally_bounded, clock, reset, state_ff == S_NBR, (tally_sum <= {1'b0, deg_ff}), "neighbor tally exceeds degree")
   `GMU_ASSERT_NXT(a_bank_only_at_end, clock, reset, state_ff != S_WRITE, $stable(bank_ff), "color bank swapped outside round end")
   `GMU_ASSERT_IMP(a_pipe_ordered, clock, reset, p2_ff, $past(p1_ff), "color lookup without adjacency read")

endmodule

// ===== test/graph_majority_update_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_majority_update_test
// Drives color, degree, neighbor, update and read requests into the majority
// update block, with random gaps and stalls on both channels. A shadow copy
// of the graph predicts every response, and each response is checked field
// by field in order.
// ----------------------------------------------------------------------------
module graph_majority_update_test;
   import gmu_pkg::*;

   class graph_color_tracker;
      logic [COLOR_W-1:0] color_bank [2][MAX_VERTICES];
      logic               bank_sel;
      logic [DEG_W-1:0]   degree [MAX_VERTICES];
      logic [VAL_W-1:0]   neighbor [MAX_VERTICES*MAX_DEGREE];
      bit                 neighbor_loaded [MAX_VERTICES*MAX_DEGREE];
      int                 rows;
      int                 cols;
      logic [COLOR_W-1:0] color_one;
      logic [COLOR_W-1:0] color_two;
      rsp_type            owed_responses [$];
      int                 mismatches;

      function new();
         rows       = int'(ROW_COUNT_RST);
         cols       = int'(COL_COUNT_RST);
         color_one  = COLOR_ONE_RST;
         color_two  = COLOR_TWO_RST;
         bank_sel   = 1'b0;
         mismatches = 0;
         foreach (neighbor_loaded[i]) neighbor_loaded[i] = 1'b0;
      endfunction

      function int vertex_total();
         int n;
         n = rows * cols;
         return (n > MAX_VERTICES) ? MAX_VERTICES : n;
      endfunction

      // Length of the run of loaded neighbor slots from slot zero.
      function int loaded_prefix(int v);
         int k;
         k = 0;
         while (k < MAX_DEGREE && neighbor_loaded[v*MAX_DEGREE + k]) k++;
         return k;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] which, logic [CSR_DATA_W-1:0] data);
         case (which)
            CSR_ROW_COUNT: rows = int'(data[DIM_W-1:0]);
            CSR_COL_COUNT: cols = int'(data[DIM_W-1:0]);
            CSR_COLOR_ONE: color_one = data;
            CSR_COLOR_TWO: color_two = data;
            default: ;
         endcase
      endfunction

      function void majority_round();
         int n;
         int ones;
         int twos;
         int nb;
         logic [COLOR_W-1:0] hue;
         n = vertex_total();
         for (int i = 0; i < MAX_VERTICES; i++) begin
            ones = 0;
            twos = 0;
            if (i < n) begin
               for (int j = 0; j < int'(degree[i]); j++) begin
                  nb = int'(neighbor[i*MAX_DEGREE + j]);
                  if (nb < n) begin
                     hue = color_bank[bank_sel][nb];
                     if (hue == color_one) ones++;
                     else if (hue == color_two) twos++;
                  end
               end
            end
            if (ones > twos) color_bank[!bank_sel][i] = color_one;
            else if (twos > ones) color_bank[!bank_sel][i] = color_two;
            else color_bank[!bank_sel][i] = color_bank[bank_sel][i];
         end
         bank_sel = !bank_sel;
      endfunction

      function logic absorb_request(req_type r);
         rsp_type owed;
         int n;
         int v;
         owed = '0;
         n = vertex_total();
         v = int'(r.vertex);
         case (r.command)
            CMD_WRITE_COLOR:
               if (v < n) color_bank[bank_sel][v] = r.value;
               else owed.status = STATUS_ERROR;
            CMD_WRITE_DEGREE:
               if (v < n && int'(r.value) <= MAX_DEGREE) degree[v] = r.value[DEG_W-1:0];
               else owed.status = STATUS_ERROR;
            CMD_WRITE_NEIGHBOR:
               if (v < n && int'(r.slot) < MAX_DEGREE && int'(r.value) < n) begin
                  neighbor[v*MAX_DEGREE + int'(r.slot)]        = r.value;
                  neighbor_loaded[v*MAX_DEGREE + int'(r.slot)] = 1'b1;
               end else begin
                  owed.status = STATUS_ERROR;
               end
            CMD_UPDATE:
               majority_round();
            CMD_READ_COLOR:
               if (v < n) owed.read_color = color_bank[bank_sel][v];
               else owed.status = STATUS_ERROR;
            default:
               owed.status = STATUS_ERROR;
         endcase
         owed_responses.push_back(owed);
         return owed.status;
      endfunction

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $time, what);
         mismatches++;
      endtask

      task match_response(rsp_type got);
         rsp_type owed;
         if (owed_responses.size() == 0) begin
            report_mismatch($sformatf("response %h with nothing outstanding", got));
            return;
         end
         owed = owed_responses.pop_front();
         if (got.read_color !== owed.read_color)
            report_mismatch($sformatf("read_color %h, predicted %h",
                                      got.read_color, owed.read_color));
         if (got.status !== owed.status)
            report_mismatch($sformatf("status %b, predicted %b", got.status, owed.status));
      endtask

      function int outstanding();
         return owed_responses.size();
      endfunction
   endclass

   // Side of the square grid whose colors and neighbor lists are all loaded;
   // every grid that runs a round fits inside it; larger ones read only written colors.
   localparam int LOAD_SIDE = 4;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   graph_color_tracker tracker;
   bit                 calm   = 1'b0;  // no gaps and no stalls while set
   int                 landed = 0;     // requests accepted with status ok

   // Random phases: grid shape and the two counted colors.
   int phase_rows [6] = '{4, 1, 2, 3, 16, 2};
   int phase_cols [6] = '{4, 1, 8, 5, 1, 2};
   int phase_one  [6] = '{46, 0, 255, 46, 7, 46};
   int phase_two  [6] = '{88, 255, 0, 88, 88, 46};

   graph_majority_update u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Response side: check what the block hands over at this edge, then pick
   // whether to stall the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.match_response(rsp_data);
      rsp_stall <= !calm && ($urandom_range(0, 99) < 24);
   end

   // Send one request; hold it until the block takes it, then let the
   // tracker predict its response. Leaves req_valid high on return.
   task automatic issue(logic [CMD_W-1:0] command, int vertex, int slot, int value);
      req_type item;
      item.command = command;
      item.vertex  = vertex[VTX_W-1:0];
      item.slot    = slot[SLOT_W-1:0];
      item.value   = value[VAL_W-1:0];
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (tracker.absorb_request(item) == STATUS_OK) landed++;
   endtask

   // Drop valid, wait for every outstanding response, then let the block settle.
   task automatic drain_and_settle(int settle);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Leaves csr_we high; the caller drops it after the last write.
   task automatic write_csr(logic [CSR_IDX_W-1:0] which, int data);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= data[CSR_DATA_W-1:0];
      @(posedge clock);
      tracker.set_register(which, data[CSR_DATA_W-1:0]);
   endtask

   task automatic configure(int rows, int cols, int one, int two);
      drain_and_settle(8);
      write_csr(CSR_ROW_COUNT, rows);
      write_csr(CSR_COL_COUNT, cols);
      write_csr(CSR_COLOR_ONE, one);
      write_csr(CSR_COLOR_TWO, two);
      csr_we <= 1'b0;
   endtask

   // Favor the two counted colors so rounds actually flip vertices.
   function automatic int pick_color();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return int'(tracker.color_one);
      if (roll < 80) return int'(tracker.color_two);
      return $urandom_range(0, 255);
   endfunction

   // Mostly in range; now and then any index, to hit the range errors.
   function automatic int pick_vertex();
      if ($urandom_range(0, 99) < 90) return $urandom_range(0, tracker.vertex_total() - 1);
      return $urandom_range(0, 255);
   endfunction

   function automatic int pick_neighbor();
      if ($urandom_range(0, 99) < 92) return $urandom_range(0, tracker.vertex_total() - 1);
      return $urandom_range(0, 255);
   endfunction

   // Load slots 0..want-1, then the count. Clip the count to the slots that
   // really hold an entry so a round never walks an unloaded slot.
   task automatic load_neighbor_list(int v, int want);
      int depth;
      for (int s = 0; s < want; s++) issue(CMD_WRITE_NEIGHBOR, v, s, pick_neighbor());
      depth = want;
      if (v < tracker.vertex_total() && tracker.loaded_prefix(v) < depth)
         depth = tracker.loaded_prefix(v);
      issue(CMD_WRITE_DEGREE, v, $urandom_range(0, MAX_DEGREE - 1), depth);
   endtask

   task automatic random_request();
      int roll;
      int v;
      int want;
      roll = $urandom_range(0, 99);
      v    = pick_vertex();
      if (roll < 22) begin
         issue(CMD_WRITE_COLOR, v, $urandom_range(0, 7), pick_color());
      end else if (roll < 32) begin
         if ($urandom_range(0, 99) < 85) begin
            want = $urandom_range(0, MAX_DEGREE);
            if (v < tracker.vertex_total() && tracker.loaded_prefix(v) < want)
               want = tracker.loaded_prefix(v);
         end else begin
            want = $urandom_range(MAX_DEGREE + 1, 255);
         end
         issue(CMD_WRITE_DEGREE, v, $urandom_range(0, 7), want);
      end else if (roll < 42) begin
         issue(CMD_WRITE_NEIGHBOR, v, $urandom_range(0, 7), pick_neighbor());
      end else if (roll < 52) begin
         load_neighbor_list(v, $urandom_range(0, MAX_DEGREE));
      end else if (roll < 60) begin
         issue(CMD_UPDATE, $urandom_range(0, 255), $urandom_range(0, 7), $urandom_range(0, 255));
      end else if (roll < 94) begin
         issue(CMD_READ_COLOR, v, $urandom_range(0, 7), $urandom_range(0, 255));
      end else begin
         issue(CMD_W'($urandom_range(int'(CMD_READ_COLOR) + 1, (1 << CMD_W) - 1)),
               v, $urandom_range(0, 7), $urandom_range(0, 255));
      end
   endtask

   initial begin
      int goal;
      bit paused;
      tracker = new();
      paused  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Full-size grid: extreme vertices and values, a count above the
      // maximum and the unused commands. No round runs at this size.
      issue(CMD_WRITE_COLOR, MAX_VERTICES - 1, 7, 255);
      issue(CMD_READ_COLOR, MAX_VERTICES - 1, 0, 0);
      issue(CMD_WRITE_COLOR, 0, 0, 0);
      issue(CMD_READ_COLOR, 0, 7, 255);
      issue(CMD_WRITE_NEIGHBOR, MAX_VERTICES - 1, 7, MAX_VERTICES - 1);
      issue(CMD_WRITE_DEGREE, 6, 0, MAX_DEGREE + 1);
      issue(CMD_WRITE_DEGREE, 6, 7, 255);
      for (int c = int'(CMD_READ_COLOR) + 1; c < (1 << CMD_W); c++)
         issue(CMD_W'(c), MAX_VERTICES - 1, 7, 255);

      // Oversized grid: the vertex count saturates at the table size.
      configure(31, 20, int'(COLOR_ONE_RST), int'(COLOR_TWO_RST));
      issue(CMD_WRITE_COLOR, 200, 0, 88);
      issue(CMD_READ_COLOR, 200, 0, 0);
      issue(CMD_READ_COLOR, MAX_VERTICES - 1, 0, 0);

      // Small grid: load every color and every neighbor count in it, so no
      // round or read ever touches an entry that was never written.
      configure(LOAD_SIDE, LOAD_SIDE, int'(COLOR_ONE_RST), int'(COLOR_TWO_RST));
      for (int v = 0; v < LOAD_SIDE * LOAD_SIDE; v++)
         issue(CMD_WRITE_COLOR, v, $urandom_range(0, 7), pick_color());
      for (int v = 0; v < LOAD_SIDE * LOAD_SIDE; v++)
         load_neighbor_list(v, ($urandom_range(0, 9) == 0) ? MAX_DEGREE : $urandom_range(0, 4));
      load_neighbor_list(5, MAX_DEGREE);
      issue(CMD_UPDATE, 0, 0, 0);
      issue(CMD_READ_COLOR, 5, 0, 0);

      // Shrink to six vertices: vertex and neighbor range errors, and a round
      // over stale neighbors that also copies the vertices beyond the count.
      configure(2, 3, int'(COLOR_ONE_RST), int'(COLOR_TWO_RST));
      issue(CMD_WRITE_COLOR, 6, 0, 46);
      issue(CMD_WRITE_DEGREE, MAX_VERTICES - 1, 0, 1);
      issue(CMD_WRITE_NEIGHBOR, 1, 2, 6);
      issue(CMD_WRITE_NEIGHBOR, MAX_VERTICES - 1, 0, 0);
      issue(CMD_READ_COLOR, 6, 0, 0);
      issue(CMD_UPDATE, 0, 0, 0);
      issue(CMD_READ_COLOR, 1, 0, 0);

      // Both counted colors equal: matches count toward the first only.
      configure(LOAD_SIDE, LOAD_SIDE, int'(COLOR_TWO_RST), int'(COLOR_TWO_RST));
      issue(CMD_UPDATE, 0, 0, 0);
      issue(CMD_READ_COLOR, 5, 0, 0);

      // Random phases, one per register setting; the third runs without gaps
      // or stalls, and the first pauses midway until all responses are in.
      for (int phase = 0; phase < 6; phase++) begin
         configure(phase_rows[phase], phase_cols[phase], phase_one[phase], phase_two[phase]);
         calm = (phase == 2);
         goal = landed + 26;
         while (landed < goal) begin
            random_request();
            if (phase == 0 && !paused && landed >= goal - 13) begin
               drain_and_settle(4);
               paused = 1'b1;
            end
         end
      end
      calm = 1'b0;

      drain_and_settle(64);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("PASS graph_majority_update");
      end else begin
         $display("FAIL graph_majority_update");
      end
      $finish;
   end

   // Hard stop well past the slowest correct run.
   initial begin
      #3_000_000;
      $display("FAIL graph_majority_update");
      $finish;
   end

endmodule
